@@ src/pqls_pkg.sv @@
// ----------------------------------------------------------------------------
// pqls_pkg
// Shared types and constants for the linear-scan priority queue.
// ----------------------------------------------------------------------------
package pqls_pkg;

    localparam int DEPTH_DEF = 8;
    localparam int PRIO_W    = 8;
    localparam int DATA_W    = 32;
    localparam int STAT_W    = 2;
    localparam int FILL_W    = 4;
    localparam int ENTRY_W   = PRIO_W + DATA_W;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESULT
    } t_state;

    // Control from the sequencer to the compare unit.
    typedef struct packed {
        logic cmp_en;
        logic first;
    } t_scan_ctl;

endpackage

@@ src/pqls_ram.sv @@
// ----------------------------------------------------------------------------
// pqls_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pqls_ram #(
    parameter int WIDTH = pqls_pkg::ENTRY_W,
    parameter int DEPTH = pqls_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/pqls_best.sv @@
// ----------------------------------------------------------------------------
// pqls_best
// Shared compare unit: tracks the highest priority seen during a scan.
// ----------------------------------------------------------------------------
module pqls_best #(
    parameter int DEPTH = pqls_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  pqls_pkg::t_scan_ctl         i_ctl,
    input  logic [$clog2(DEPTH)-1:0]    i_idx,
    input  logic [pqls_pkg::PRIO_W-1:0] i_prio,
    input  logic [pqls_pkg::DATA_W-1:0] i_payload,
    output logic [$clog2(DEPTH)-1:0]    o_best_idx_nxt,
    output logic [pqls_pkg::PRIO_W-1:0] o_best_prio,
    output logic [pqls_pkg::DATA_W-1:0] o_best_payload
);

    localparam int AW = $clog2(DEPTH);

    logic [AW-1:0]               r_best_idx;
    logic [pqls_pkg::PRIO_W-1:0] r_best_prio;
    logic [pqls_pkg::DATA_W-1:0] r_best_payload;
    logic                        take;

    // Strictly greater, so the earliest slot wins a tie.
    assign take           = i_ctl.first || (i_prio > r_best_prio);
    assign o_best_idx_nxt = take ? i_idx : r_best_idx;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en && take) begin
            r_best_idx     <= i_idx;
            r_best_prio    <= i_prio;
            r_best_payload <= i_payload;
        end
    end

    assign o_best_prio    = r_best_prio;
    assign o_best_payload = r_best_payload;

endmodule

@@ src/pqls_seq.sv @@
// ----------------------------------------------------------------------------
// pqls_seq
// Sequencer: insert, scan for the maximum, shift down, and result hand-off.
// ----------------------------------------------------------------------------
module pqls_seq #(
    parameter int DEPTH = pqls_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Request side
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_req_type,
    input  logic [pqls_pkg::PRIO_W-1:0]  i_priority_req,
    input  logic [pqls_pkg::DATA_W-1:0]  i_payload,
    // Entry RAM
    output logic                         o_ram_we,
    output logic [$clog2(DEPTH)-1:0]     o_ram_waddr,
    output logic [pqls_pkg::ENTRY_W-1:0] o_ram_wdata,
    output logic                         o_ram_re,
    output logic [$clog2(DEPTH)-1:0]     o_ram_raddr,
    input  logic [pqls_pkg::ENTRY_W-1:0] i_ram_rdata,
    // Compare unit
    output pqls_pkg::t_scan_ctl          o_scan_ctl,
    output logic [$clog2(DEPTH)-1:0]     o_scan_idx,
    input  logic [$clog2(DEPTH)-1:0]     i_best_idx_nxt,
    input  logic [pqls_pkg::PRIO_W-1:0]  i_best_prio,
    input  logic [pqls_pkg::DATA_W-1:0]  i_best_payload,
    // Result
    output logic                         o_res_valid,
    input  logic                         i_res_take,
    output pqls_pkg::t_status            o_res_status,
    output logic [pqls_pkg::PRIO_W-1:0]  o_res_prio,
    output logic [pqls_pkg::DATA_W-1:0]  o_res_payload,
    output logic [pqls_pkg::FILL_W-1:0]  o_res_fill
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    pqls_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_idx, n_idx;
    pqls_pkg::t_status r_status, n_status;
    logic              r_rm, n_rm;

    logic          accept;
    logic [CW-1:0] idx_p1, idx_p2, best_p1;

    assign accept  = i_in_valid && (r_state == pqls_pkg::S_IDLE);
    assign idx_p1  = CW'(r_idx) + CW'(1);
    assign idx_p2  = CW'(r_idx) + CW'(2);
    assign best_p1 = CW'(i_best_idx_nxt) + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pqls_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx    <= n_idx;
        r_status <= n_status;
        r_rm     <= n_rm;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_status    = r_status;
        n_rm        = r_rm;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_idx;
        o_ram_wdata = i_ram_rdata;
        o_ram_re    = 1'b0;
        o_ram_raddr = idx_p1[AW-1:0];
        o_scan_ctl  = '0;
        o_res_valid = 1'b0;

        case (r_state)
            pqls_pkg::S_IDLE: begin
                if (accept) begin
                    n_rm    = 1'b0;
                    n_state = pqls_pkg::S_RESULT;
                    if (i_req_type == pqls_pkg::REQ_INSERT) begin
                        if (r_count < CW'(DEPTH)) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = r_count[AW-1:0];
                            o_ram_wdata = {i_priority_req, i_payload};
                            n_count     = r_count + CW'(1);
                            n_status    = pqls_pkg::ST_DONE;
                        end else begin
                            n_status = pqls_pkg::ST_FULL;
                        end
                    end else if (r_count == '0) begin
                        n_status = pqls_pkg::ST_EMPTY;
                    end else begin
                        o_ram_re    = 1'b1;
                        o_ram_raddr = '0;
                        n_idx       = '0;
                        n_state     = pqls_pkg::S_SCAN;
                    end
                end
            end
            pqls_pkg::S_SCAN: begin
                o_scan_ctl.cmp_en = 1'b1;
                o_scan_ctl.first  = (r_idx == '0);
                if (idx_p1 != r_count) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = idx_p1[AW-1:0];
                    n_idx       = idx_p1[AW-1:0];
                end else begin
                    n_rm     = 1'b1;
                    n_status = pqls_pkg::ST_DONE;
                    if (best_p1 < r_count) begin
                        // Fetch the slot above the winner to start closing the gap.
                        o_ram_re    = 1'b1;
                        o_ram_raddr = best_p1[AW-1:0];
                        n_idx       = i_best_idx_nxt;
                        n_state     = pqls_pkg::S_SHIFT;
                    end else begin
                        n_count = r_count - CW'(1);
                        n_state = pqls_pkg::S_RESULT;
                    end
                end
            end
            pqls_pkg::S_SHIFT: begin
                // Slot r_idx + 1 arrives now and moves down into slot r_idx.
                o_ram_we    = 1'b1;
                o_ram_waddr = r_idx;
                o_ram_wdata = i_ram_rdata;
                if (idx_p2 < r_count) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = idx_p2[AW-1:0];
                    n_idx       = idx_p1[AW-1:0];
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = pqls_pkg::S_RESULT;
                end
            end
            pqls_pkg::S_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = pqls_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pqls_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall    = (r_state != pqls_pkg::S_IDLE);
    assign o_scan_idx    = r_idx;
    assign o_res_status  = r_status;
    assign o_res_prio    = r_rm ? i_best_prio : '0;
    assign o_res_payload = r_rm ? i_best_payload : '0;
    assign o_res_fill    = pqls_pkg::FILL_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pqls_pkg::S_SCAN || r_state == pqls_pkg::S_SHIFT) |-> r_count != '0)
        else $error("scan or shift on an empty queue");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pqls_pkg::S_SHIFT) |-> idx_p1 < r_count)
        else $error("shift reads past the stored entries");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("request accepted without leaving idle");

endmodule

@@ src/priority_queue_linear_scan_core.sv @@
// An insert or a remove on an empty queue goes straight from idle to the result state, then into the output register.
// A remove scans every stored entry, then shifts each entry above the winner down one slot:
// one compare unit reads one entry per cycle, then one RAM port pair shifts one entry per cycle.
// Throughput: one transaction at a time; the next one is taken when the result is handed over.
// Reset (synchronous, active low) empties the queue; entry storage is not cleared.
// ----------------------------------------------------------------------------
// priority_queue_linear_scan_core
// Bounded priority queue in arrival order with highest-priority removal.
// ----------------------------------------------------------------------------
module priority_queue_linear_scan_core #(
    parameter int DEPTH = pqls_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_req_type,
    input  logic [pqls_pkg::PRIO_W-1:0]         i_priority_req,
    input  logic signed [pqls_pkg::DATA_W-1:0]  i_payload,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [pqls_pkg::STAT_W-1:0]         o_status,
    output logic [pqls_pkg::PRIO_W-1:0]         o_out_priority,
    output logic signed [pqls_pkg::DATA_W-1:0]  o_out_payload,
    output logic [pqls_pkg::FILL_W-1:0]         o_fill_level
);

    localparam int AW = $clog2(DEPTH);

    logic                         ram_we, ram_re;
    logic [AW-1:0]                ram_waddr, ram_raddr;
    logic [pqls_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
    pqls_pkg::t_scan_ctl          scan_ctl;
    logic [AW-1:0]                scan_idx, best_idx_nxt;
    logic [pqls_pkg::PRIO_W-1:0]  best_prio, res_prio;
    logic [pqls_pkg::DATA_W-1:0]  best_payload, res_payload;
    logic                         res_valid, res_take;
    pqls_pkg::t_status            res_status;
    logic [pqls_pkg::FILL_W-1:0]  res_fill;

    logic                         r_out_valid;
    pqls_pkg::t_status            r_out_status;
    logic [pqls_pkg::PRIO_W-1:0]  r_out_prio;
    logic [pqls_pkg::DATA_W-1:0]  r_out_payload;
    logic [pqls_pkg::FILL_W-1:0]  r_out_fill;

    pqls_ram #(
        .WIDTH (pqls_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pqls_best #(
        .DEPTH (DEPTH)
    ) u_best (
        .i_clk          (i_clk),
        .i_ctl          (scan_ctl),
        .i_idx          (scan_idx),
        .i_prio         (ram_rdata[pqls_pkg::ENTRY_W-1:pqls_pkg::DATA_W]),
        .i_payload      (ram_rdata[pqls_pkg::DATA_W-1:0]),
        .o_best_idx_nxt (best_idx_nxt),
        .o_best_prio    (best_prio),
        .o_best_payload (best_payload)
    );

    pqls_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_priority_req (i_priority_req),
        .i_payload      (i_payload),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_re       (ram_re),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata),
        .o_scan_ctl     (scan_ctl),
        .o_scan_idx     (scan_idx),
        .i_best_idx_nxt (best_idx_nxt),
        .i_best_prio    (best_prio),
        .i_best_payload (best_payload),
        .o_res_valid    (res_valid),
        .i_res_take     (res_take),
        .o_res_status   (res_status),
        .o_res_prio     (res_prio),
        .o_res_payload  (res_payload),
        .o_res_fill     (res_fill)
    );

    // The output register frees up when it is empty or its transaction completes.
    assign res_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
        if (res_take && res_valid) begin
            r_out_status  <= res_status;
            r_out_prio    <= res_prio;
            r_out_payload <= res_payload;
            r_out_fill    <= res_fill;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_out_priority = r_out_prio;
    assign o_out_payload  = r_out_payload;
    assign o_fill_level   = r_out_fill;

endmodule

@@ bench/pqls_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pqls_checker
// Watches both channels of the priority queue core. Every accepted request is
// run through a local copy of the queue to predict its reply. Every reply
// handed over is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pqls_checker #(
    parameter int DEPTH = pqls_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic                                i_req_type,
    input  logic [pqls_pkg::PRIO_W-1:0]         i_priority_req,
    input  logic signed [pqls_pkg::DATA_W-1:0]  i_payload,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [pqls_pkg::STAT_W-1:0]         i_status,
    input  logic [pqls_pkg::PRIO_W-1:0]         i_out_priority,
    input  logic signed [pqls_pkg::DATA_W-1:0]  i_out_payload,
    input  logic [pqls_pkg::FILL_W-1:0]         i_fill_level,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    typedef struct {
        pqls_pkg::t_status                   status;
        logic [pqls_pkg::PRIO_W-1:0]         prio;
        logic signed [pqls_pkg::DATA_W-1:0]  data;
        logic [pqls_pkg::FILL_W-1:0]         fill;
    } t_reply;

    // Local copy of the queue, oldest entry in slot 0.
    logic [pqls_pkg::PRIO_W-1:0]         slot_prio [DEPTH];
    logic signed [pqls_pkg::DATA_W-1:0]  slot_data [DEPTH];
    int                                  stored;

    t_reply replies_due [$];
    int     reported;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        reported     = 0;
        stored       = 0;
    end

    function automatic t_reply serve_request(
        input logic                               req,
        input logic [pqls_pkg::PRIO_W-1:0]        prio,
        input logic signed [pqls_pkg::DATA_W-1:0] data
    );
        t_reply r;
        int     best;
        r.status = pqls_pkg::ST_DONE;
        r.prio   = '0;
        r.data   = '0;
        if (req == pqls_pkg::REQ_INSERT) begin
            if (stored < DEPTH) begin
                slot_prio[stored] = prio;
                slot_data[stored] = data;
                stored++;
            end else begin
                r.status = pqls_pkg::ST_FULL;
            end
        end else if (stored == 0) begin
            r.status = pqls_pkg::ST_EMPTY;
        end else begin
            // Strictly greater keeps the earliest entry on a tie.
            best = 0;
            for (int i = 1; i < stored; i++) begin
                if (slot_prio[i] > slot_prio[best]) best = i;
            end
            r.prio = slot_prio[best];
            r.data = slot_data[best];
            for (int i = best; i + 1 < stored; i++) begin
                slot_prio[i] = slot_prio[i + 1];
                slot_data[i] = slot_data[i + 1];
            end
            stored--;
        end
        r.fill = stored[pqls_pkg::FILL_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            replies_due.delete();
            stored = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0) begin
                    o_fail_count++;
                    if (reported < 10) begin
                        reported++;
                        $display({"%0t: reply with nothing outstanding: ",
                                  "status %0d prio %0d data %0d fill %0d"},
                                 $realtime, i_status, i_out_priority, i_out_payload,
                                 i_fill_level);
                    end
                end else begin
                    want = replies_due.pop_front();
                    if (i_status !== want.status || i_out_priority !== want.prio ||
                        i_out_payload !== want.data || i_fill_level !== want.fill) begin
                        o_fail_count++;
                        if (reported < 10) begin
                            reported++;
                            $display({"%0t: reply mismatch: status %0d/%0d prio %0d/%0d ",
                                      "data %0d/%0d fill %0d/%0d (expected/actual)"},
                                     $realtime, want.status, i_status, want.prio,
                                     i_out_priority, want.data, i_out_payload,
                                     want.fill, i_fill_level);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                replies_due.push_back(serve_request(i_req_type, i_priority_req, i_payload));
            end
        end
        o_pending = replies_due.size();
    end

endmodule

@@ bench/tb_priority_queue_linear_scan_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_priority_queue_linear_scan_core
// Drives insert and remove requests into the priority queue core: a directed
// run through empty, full and tie cases, then biased random traffic with
// varying idle and stall patterns. Checking is done by pqls_checker.
// ----------------------------------------------------------------------------
module tb_priority_queue_linear_scan_core;

    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 40;

    logic                                i_clk          = 1'b0;
    logic                                i_rst_n        = 1'b0;
    logic                                i_in_valid     = 1'b0;
    logic                                i_req_type     = pqls_pkg::REQ_INSERT;
    logic [pqls_pkg::PRIO_W-1:0]         i_priority_req = '0;
    logic signed [pqls_pkg::DATA_W-1:0]  i_payload      = '0;
    logic                                i_out_stall    = 1'b0;
    logic                                o_in_stall;
    logic                                o_out_valid;
    logic [pqls_pkg::STAT_W-1:0]         o_status;
    logic [pqls_pkg::PRIO_W-1:0]         o_out_priority;
    logic signed [pqls_pkg::DATA_W-1:0]  o_out_payload;
    logic [pqls_pkg::FILL_W-1:0]         o_fill_level;

    int fail_count;
    int pending;
    int cycle_count  = 0;
    int tx_idle_pct  = 33;
    int rx_stall_pct = 82;
    int hold_req     = 0;
    int hold_left    = 0;

    priority_queue_linear_scan_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_priority_req (i_priority_req),
        .i_payload      (i_payload),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_out_priority (o_out_priority),
        .o_out_payload  (o_out_payload),
        .o_fill_level   (o_fill_level)
    );

    pqls_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_priority_req (i_priority_req),
        .i_payload      (i_payload),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_status       (o_status),
        .i_out_priority (o_out_priority),
        .i_out_payload  (o_out_payload),
        .i_fill_level   (o_fill_level),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off once one is requested.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_req > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_req;
            hold_req    = 0;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Called and returning at a falling edge. Valid stays high on return so
    // that back-to-back transactions need no extra assignment.
    task automatic offer(input logic req, input logic [pqls_pkg::PRIO_W-1:0] prio,
                         input logic [pqls_pkg::DATA_W-1:0] data);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_priority_req <= prio;
        i_payload      <= data;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int bias_set [5];
        int insert_pct;
        logic req;
        logic [pqls_pkg::PRIO_W-1:0] prio;
        logic [31:0] rnd;

        bias_set   = '{20, 50, 80, 95, 5};
        insert_pct = 50;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: remove from empty, fill with extremes and ties, overflow,
        // empty it again and remove once more past empty.
        offer(pqls_pkg::REQ_REMOVE, 8'd0, 32'h0);
        offer(pqls_pkg::REQ_INSERT, 8'd0,   32'h8000_0000);
        offer(pqls_pkg::REQ_INSERT, 8'd255, 32'h7FFF_FFFF);
        offer(pqls_pkg::REQ_INSERT, 8'd255, 32'hFFFF_FFFF);
        offer(pqls_pkg::REQ_INSERT, 8'd0,   32'h0000_0000);
        offer(pqls_pkg::REQ_INSERT, 8'd128, 32'h0000_0001);
        offer(pqls_pkg::REQ_INSERT, 8'd127, 32'hFFFF_FFFE);
        offer(pqls_pkg::REQ_INSERT, 8'd255, 32'h5555_5555);
        offer(pqls_pkg::REQ_INSERT, 8'd1,   32'hAAAA_AAAA);
        offer(pqls_pkg::REQ_INSERT, 8'd200, 32'h1234_5678);
        for (int i = 0; i < pqls_pkg::DEPTH_DEF + 1; i++) begin
            offer(pqls_pkg::REQ_REMOVE, 8'hFF, 32'hFFFF_FFFF);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 150) begin
                tx_idle_pct  = 82;
                rx_stall_pct = 33;
            end
            if (n == 300) begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            if (n == 225 || n == 400) drain();
            if (n == 340) hold_req = 120;
            if (n % 40 == 0) insert_pct = bias_set[$urandom_range(4)];

            req = ($urandom_range(99) < insert_pct) ? pqls_pkg::REQ_INSERT
                                                    : pqls_pkg::REQ_REMOVE;
            // Narrow priorities make ties common; the edges get their own share.
            case ($urandom_range(3))
                0: begin
                    rnd  = $urandom_range(3);
                    prio = rnd[pqls_pkg::PRIO_W-1:0];
                end
                1: begin
                    prio = $urandom_range(1) ? 8'd255 : 8'd0;
                end
                default: begin
                    rnd  = $urandom_range(255);
                    prio = rnd[pqls_pkg::PRIO_W-1:0];
                end
            endcase
            offer(req, prio, $urandom);
        end

        drain();
        repeat (SETTLE) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/pqls_pkg.sv
src/pqls_ram.sv
src/pqls_best.sv
src/pqls_seq.sv
src/priority_queue_linear_scan_core.sv
bench/pqls_checker.sv
bench/tb_priority_queue_linear_scan_core.sv
